FILE: sv/stable_sorted_priority_queue_assert.svh
// Assertion macros shared by the queue checker.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssq assertion failed");

// Next-cycle implication, checked outside reset.
`define SSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssq assertion failed");

`endif

FILE: sv/ssq_pkg.sv
// Types and codes shared by the sorted priority queue modules.
package ssq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic        command;
    logic [7:0]  priority_req;
    logic [15:0] payload;
  } ssq_in_t;

  typedef struct packed {
    logic        head_valid;
    logic [7:0]  head_priority;
    logic [15:0] head_payload;
    logic [4:0]  occupancy;
    logic [1:0]  status;
  } ssq_out_t;

  // Operation broadcast to every cell in a cycle.
  typedef struct packed {
    logic ins;
    logic rem;
  } ssq_ctrl_t;

endpackage

FILE: sv/ssq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module ssq_cell import ssq_pkg::*; #(
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  ssq_ctrl_t               ctrl,
  input  logic                    occupied,
  input  logic [7:0]              new_prio,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic                    left_keep,
  input  logic [7:0]              left_prio,
  input  logic [PAYLOAD_BITS-1:0] left_payload,
  input  logic [7:0]              right_prio,
  input  logic [PAYLOAD_BITS-1:0] right_payload,
  output logic                    keep,
  output logic [7:0]              prio,
  output logic [PAYLOAD_BITS-1:0] payload,
  output logic [7:0]              prio_next,
  output logic [PAYLOAD_BITS-1:0] payload_next
);

  // An entry stays put when it ranks at or above the new one, which keeps ties in
  // arrival order.
  assign keep = occupied && (prio >= new_prio);

  always_comb begin
    prio_next    = prio;
    payload_next = payload;
    if (ctrl.ins) begin
      if (!keep) begin
        if (left_keep) begin
          prio_next    = new_prio;
          payload_next = new_payload;
        end else begin
          prio_next    = left_prio;
          payload_next = left_payload;
        end
      end
    end else if (ctrl.rem) begin
      prio_next    = right_prio;
      payload_next = right_payload;
    end
  end

  always_ff @(posedge clk) begin
    prio    <= prio_next;
    payload <= payload_next;
  end

endmodule

FILE: sv/stable_sorted_priority_queue.sv
// Stable sorted priority queue built from a chain of shifting cells.
//
//   channel  | signals                      | carries
//   ---------+------------------------------+-----------------------------------
//   in       | in_valid, in_ready, in_data  | command, priority, payload tag
//   out      | out_valid, out_ready, out_data | head entry, occupancy, status
//
// For each beat, all cells compare against the new priority in parallel and shift
// by one slot, and the result is registered on the output.
// A new beat is taken each cycle while the output register is empty or drained.
// Reset empties the queue and the output register; slot contents are not cleared.
// A stalled output holds its beat and blocks further input beats.
module stable_sorted_priority_queue import ssq_pkg::*; #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ssq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ssq_out_t out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             fire;
  logic             full;
  logic             empty;
  logic [1:0]       status;
  ssq_ctrl_t        ctrl;

  logic [PAYLOAD_BITS-1:0] new_payload;

  logic [DEPTH-1:0]        keep;
  logic [7:0]              prio         [DEPTH];
  logic [PAYLOAD_BITS-1:0] payload      [DEPTH];
  logic [7:0]              prio_next    [DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_next [DEPTH];

  assign in_ready    = !out_valid || out_ready;
  assign fire        = in_valid && in_ready;
  assign full        = (count == CNT_W'(DEPTH));
  assign empty       = (count == '0);
  assign new_payload = PAYLOAD_BITS'(in_data.payload);

  always_comb begin
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    status     = STATUS_OK;
    count_next = count;
    if (fire) begin
      if (in_data.command == CMD_INSERT) begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          ctrl.ins   = 1'b1;
          count_next = count + 1'b1;
        end
      end else begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          ctrl.rem   = 1'b1;
          count_next = count - 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    l_keep;
    logic [7:0]              l_prio;
    logic [PAYLOAD_BITS-1:0] l_payload;
    logic [7:0]              r_prio;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // The head slot sees a left neighbor that always ranks higher, so it takes
    // the new entry whenever its own entry does not stay.
    if (i == 0) begin : g_head
      assign l_keep    = 1'b1;
      assign l_prio    = in_data.priority_req;
      assign l_payload = new_payload;
    end else begin : g_body
      assign l_keep    = keep[i-1];
      assign l_prio    = prio[i-1];
      assign l_payload = payload[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_prio    = prio[i];
      assign r_payload = payload[i];
    end else begin : g_inner
      assign r_prio    = prio[i+1];
      assign r_payload = payload[i+1];
    end

    ssq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (count > CNT_W'(i)),
      .new_prio     (in_data.priority_req),
      .new_payload  (new_payload),
      .left_keep    (l_keep),
      .left_prio    (l_prio),
      .left_payload (l_payload),
      .right_prio   (r_prio),
      .right_payload(r_payload),
      .keep         (keep[i]),
      .prio         (prio[i]),
      .payload      (payload[i]),
      .prio_next    (prio_next[i]),
      .payload_next (payload_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.head_valid    <= (count_next != '0);
      out_data.head_priority <= (count_next != '0) ? prio_next[0] : 8'd0;
      out_data.head_payload  <= (count_next != '0) ? 16'(payload_next[0]) : 16'd0;
      out_data.occupancy     <= 5'(count_next);
      out_data.status        <= status;
    end
  end

endmodule

FILE: sv/ssq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
`include "stable_sorted_priority_queue_assert.svh"

module ssq_checker import ssq_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input ssq_out_t out_data
);

  `SSQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `SSQ_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready)
  `SSQ_ASSERT_NOW(a_empty_head_zero, out_valid && !out_data.head_valid,
    out_data.head_priority == 8'd0 && out_data.head_payload == 16'd0 && out_data.occupancy == 5'd0)
  `SSQ_ASSERT_NOW(a_full_drop_has_head, out_valid && out_data.status == STATUS_FULL,
    out_data.head_valid)
  `SSQ_ASSERT_NOW(a_empty_remove_is_empty, out_valid && out_data.status == STATUS_EMPTY,
    !out_data.head_valid && out_data.occupancy == 5'd0)

endmodule

bind stable_sorted_priority_queue ssq_checker u_ssq_checker (.*);
